FILE: rtl/spi_pkg.sv
`default_nettype none
package spi_pkg;

  localparam int Q_BITS = 32;
  localparam int PNT_BITS = 48;

  typedef enum logic [1:0] {
    REL_DEGENERATE = 2'd0,
    REL_CROSS      = 2'd1,
    REL_PARALLEL   = 2'd2,
    REL_COLLINEAR  = 2'd3
  } relation_t;

endpackage
`default_nettype wire

FILE: rtl/spi_pair_if.sv
`default_nettype none
interface spi_pair_if #(
  parameter int COORD_BITS = 16
);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] point_a_x;
  logic signed [COORD_BITS-1:0] point_a_y;
  logic signed [COORD_BITS-1:0] point_b_x;
  logic signed [COORD_BITS-1:0] point_b_y;
  logic signed [COORD_BITS-1:0] point_c_x;
  logic signed [COORD_BITS-1:0] point_c_y;
  logic signed [COORD_BITS-1:0] point_d_x;
  logic signed [COORD_BITS-1:0] point_d_y;

  modport source (
    output valid, point_a_x, point_a_y, point_b_x, point_b_y,
    output point_c_x, point_c_y, point_d_x, point_d_y,
    input  ready
  );
  modport sink (
    input  valid, point_a_x, point_a_y, point_b_x, point_b_y,
    input  point_c_x, point_c_y, point_d_x, point_d_y,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/spi_result_if.sv
`default_nettype none
interface spi_result_if
  import spi_pkg::*;
#(
  parameter int COORD_BITS = 16
);
  logic valid;
  logic ready;
  logic [1:0] relation;
  logic segments_cross;
  logic segments_overlap;
  logic signed [Q_BITS-1:0] param_s;
  logic signed [Q_BITS-1:0] param_t;
  logic signed [PNT_BITS-1:0] cross_x;
  logic signed [PNT_BITS-1:0] cross_y;
  logic signed [COORD_BITS-1:0] overlap_start_x;
  logic signed [COORD_BITS-1:0] overlap_start_y;
  logic signed [COORD_BITS-1:0] overlap_end_x;
  logic signed [COORD_BITS-1:0] overlap_end_y;

  modport source (
    output valid, relation, segments_cross, segments_overlap, param_s, param_t,
    output cross_x, cross_y, overlap_start_x, overlap_start_y,
    output overlap_end_x, overlap_end_y,
    input  ready
  );
  modport sink (
    input  valid, relation, segments_cross, segments_overlap, param_s, param_t,
    input  cross_x, cross_y, overlap_start_x, overlap_start_y,
    input  overlap_end_x, overlap_end_y,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/spi_div_cell.sv
`default_nettype none
// One quotient bit of both parameter divisions, remainders handed onward.
module spi_div_cell
  import spi_pkg::*;
#(
  parameter int UW    = 35,
  parameter int RW    = 68,
  parameter int SHIFT = 31
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [RW-1:0] rem_s_in,
  input  wire logic [RW-1:0] rem_t_in,
  input  wire logic [Q_BITS-1:0] q_s_in,
  input  wire logic [Q_BITS-1:0] q_t_in,
  input  wire logic [UW-1:0] ud_in,
  output logic               valid_out,
  output logic [RW-1:0]      rem_s_out,
  output logic [RW-1:0]      rem_t_out,
  output logic [Q_BITS-1:0]  q_s_out,
  output logic [Q_BITS-1:0]  q_t_out,
  output logic [UW-1:0]      ud_out
);

  logic [RW-1:0] ud_sh;
  logic ge_s, ge_t;
  logic [RW-1:0] rem_s_next, rem_t_next;
  logic [Q_BITS-1:0] q_s_next, q_t_next;

  always_comb begin
    ud_sh = RW'(ud_in) << SHIFT;
    ge_s = rem_s_in >= ud_sh;
    ge_t = rem_t_in >= ud_sh;
    rem_s_next = ge_s ? rem_s_in - ud_sh : rem_s_in;
    rem_t_next = ge_t ? rem_t_in - ud_sh : rem_t_in;
    q_s_next = q_s_in;
    q_t_next = q_t_in;
    q_s_next[SHIFT] = ge_s;
    q_t_next[SHIFT] = ge_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
    if (en) begin
      rem_s_out <= rem_s_next;
      rem_t_out <= rem_t_next;
      q_s_out   <= q_s_next;
      q_t_out   <= q_t_next;
      ud_out    <= ud_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/segment_pair_intersect.sv
// Path of a request: stages A, B and C, the divider cells, M1, M2, then the result register.
// Throughput: one segment pair per cycle when not stalled; the 32 divider cells, one quotient
// bit each, form a pipeline that takes a new pair every cycle.
// The whole pipeline holds while the result register is full and not taken.
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
`default_nettype none
module segment_pair_intersect
  import spi_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  spi_pair_if.sink     pair_in,
  spi_result_if.source result_out
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int PW = 2 * D;
  localparam int X  = 2 * D + 1;
  localparam int UW = X;
  localparam int RW = UW + Q_BITS + 1;
  localparam int MW = Q_BITS + D;
  localparam int SW = MW + C + FRAC_BITS + 2;

  localparam logic signed [SW-1:0] P48_MAX_W =
    {{(SW - PNT_BITS + 1){1'b0}}, {(PNT_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] P48_MIN_W =
    {{(SW - PNT_BITS + 1){1'b1}}, {(PNT_BITS - 1){1'b0}}};

  typedef struct packed {
    logic [1:0] rel;
    logic crosses;
    logic neg_s;
    logic neg_t;
    logic ovf_s;
    logic ovf_t;
    logic ovl;
    logic signed [C-1:0] sx;
    logic signed [C-1:0] sy;
    logic signed [C-1:0] ex;
    logic signed [C-1:0] ey;
    logic signed [C-1:0] ax;
    logic signed [C-1:0] ay;
    logic signed [D-1:0] bax;
    logic signed [D-1:0] bay;
  } side_t;

  logic adv;
  assign adv = !result_out.valid || result_out.ready;
  assign pair_in.ready = adv;

  // stage A: differences, products, per-axis overlap
  logic signed [D-1:0] bax, bay, dcx, dcy, acx, acy;
  logic signed [C-1:0] lo1x, hi1x, lo2x, hi2x, lo1y, hi1y, lo2y, hi2y;
  logic ovx, ovy;

  always_comb begin
    bax = D'(pair_in.point_b_x) - D'(pair_in.point_a_x);
    bay = D'(pair_in.point_b_y) - D'(pair_in.point_a_y);
    dcx = D'(pair_in.point_d_x) - D'(pair_in.point_c_x);
    dcy = D'(pair_in.point_d_y) - D'(pair_in.point_c_y);
    acx = D'(pair_in.point_a_x) - D'(pair_in.point_c_x);
    acy = D'(pair_in.point_a_y) - D'(pair_in.point_c_y);
    lo1x = (pair_in.point_a_x < pair_in.point_b_x) ? pair_in.point_a_x : pair_in.point_b_x;
    hi1x = (pair_in.point_a_x < pair_in.point_b_x) ? pair_in.point_b_x : pair_in.point_a_x;
    lo2x = (pair_in.point_c_x < pair_in.point_d_x) ? pair_in.point_c_x : pair_in.point_d_x;
    hi2x = (pair_in.point_c_x < pair_in.point_d_x) ? pair_in.point_d_x : pair_in.point_c_x;
    lo1y = (pair_in.point_a_y < pair_in.point_b_y) ? pair_in.point_a_y : pair_in.point_b_y;
    hi1y = (pair_in.point_a_y < pair_in.point_b_y) ? pair_in.point_b_y : pair_in.point_a_y;
    lo2y = (pair_in.point_c_y < pair_in.point_d_y) ? pair_in.point_c_y : pair_in.point_d_y;
    hi2y = (pair_in.point_c_y < pair_in.point_d_y) ? pair_in.point_d_y : pair_in.point_c_y;
    ovx = !(hi1x < lo2x || hi2x < lo1x);
    ovy = !(hi1y < lo2y || hi2y < lo1y);
  end

  logic a_v, a_deg, a_ovl;
  logic signed [PW-1:0] a_p0, a_p1, a_p2, a_p3, a_p4, a_p5;
  logic signed [C-1:0] a_ax, a_ay, a_sx, a_sy, a_ex, a_ey;
  logic signed [D-1:0] a_bax, a_bay;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= pair_in.valid;
    end
    if (adv) begin
      a_p0  <= dcy * bax;
      a_p1  <= dcx * bay;
      a_p2  <= acy * dcx;
      a_p3  <= acx * dcy;
      a_p4  <= acy * bax;
      a_p5  <= acx * bay;
      a_deg <= (bax == '0 && bay == '0) || (dcx == '0 && dcy == '0);
      a_ovl <= ovx && ovy;
      a_sx  <= (lo1x > lo2x) ? lo1x : lo2x;
      a_ex  <= (hi1x < hi2x) ? hi1x : hi2x;
      a_sy  <= (lo1y > lo2y) ? lo1y : lo2y;
      a_ey  <= (hi1y < hi2y) ? hi1y : hi2y;
      a_ax  <= pair_in.point_a_x;
      a_ay  <= pair_in.point_a_y;
      a_bax <= bax;
      a_bay <= bay;
    end
  end

  // stage B: cross products and classification
  logic signed [X-1:0] den_w, ns_w, nt_w;
  logic [1:0] rel_w;
  logic ovl_w;

  always_comb begin
    den_w = X'(a_p0) - X'(a_p1);
    ns_w  = X'(a_p2) - X'(a_p3);
    nt_w  = X'(a_p4) - X'(a_p5);
    if (a_deg) begin
      rel_w = REL_DEGENERATE;
    end else if (den_w != '0) begin
      rel_w = REL_CROSS;
    end else if (ns_w == '0 || nt_w == '0) begin
      rel_w = REL_COLLINEAR;
    end else begin
      rel_w = REL_PARALLEL;
    end
    ovl_w = (rel_w == REL_COLLINEAR) && a_ovl;
  end

  logic b_v;
  logic signed [X-1:0] b_den, b_ns, b_nt;
  side_t b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
    if (adv) begin
      b_den <= den_w;
      b_ns  <= ns_w;
      b_nt  <= nt_w;
      b_side.rel     <= rel_w;
      b_side.crosses <= 1'b0;
      b_side.neg_s   <= 1'b0;
      b_side.neg_t   <= 1'b0;
      b_side.ovf_s   <= 1'b0;
      b_side.ovf_t   <= 1'b0;
      b_side.ovl     <= ovl_w;
      b_side.sx      <= ovl_w ? a_sx : '0;
      b_side.sy      <= ovl_w ? a_sy : '0;
      b_side.ex      <= ovl_w ? a_ex : '0;
      b_side.ey      <= ovl_w ? a_ey : '0;
      b_side.ax      <= a_ax;
      b_side.ay      <= a_ay;
      b_side.bax     <= a_bax;
      b_side.bay     <= a_bay;
    end
  end

  // stage C: magnitudes, unit-range test, overflow of the integer part
  logic [UW-1:0] ud_w, uns_w, unt_w;
  logic [RW-1:0] rs0_w, rt0_w, udq_w;
  logic in_s, in_t;
  side_t c_side_w;

  always_comb begin
    ud_w  = b_den[X-1] ? UW'(-b_den) : UW'(b_den);
    uns_w = b_ns[X-1] ? UW'(-b_ns) : UW'(b_ns);
    unt_w = b_nt[X-1] ? UW'(-b_nt) : UW'(b_nt);
    rs0_w = RW'(uns_w) << FRAC_BITS;
    rt0_w = RW'(unt_w) << FRAC_BITS;
    udq_w = RW'(ud_w) << Q_BITS;
    if (b_den > 0) begin
      in_s = b_ns >= 0 && b_ns <= b_den;
      in_t = b_nt >= 0 && b_nt <= b_den;
    end else begin
      in_s = b_ns <= 0 && b_ns >= b_den;
      in_t = b_nt <= 0 && b_nt >= b_den;
    end
    c_side_w = b_side;
    c_side_w.crosses = (b_side.rel == REL_CROSS) && in_s && in_t;
    c_side_w.neg_s = b_ns[X-1] != b_den[X-1];
    c_side_w.neg_t = b_nt[X-1] != b_den[X-1];
    c_side_w.ovf_s = rs0_w >= udq_w;
    c_side_w.ovf_t = rt0_w >= udq_w;
  end

  logic              cv [0:Q_BITS];
  logic [RW-1:0]     crs [0:Q_BITS];
  logic [RW-1:0]     crt [0:Q_BITS];
  logic [Q_BITS-1:0] cqs [0:Q_BITS];
  logic [Q_BITS-1:0] cqt [0:Q_BITS];
  logic [UW-1:0]     cud [0:Q_BITS];
  side_t             cside [0:Q_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= b_v;
    end
    if (adv) begin
      crs[0]   <= rs0_w;
      crt[0]   <= rt0_w;
      cqs[0]   <= '0;
      cqt[0]   <= '0;
      cud[0]   <= ud_w;
      cside[0] <= c_side_w;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < Q_BITS; gi++) begin : g_cell
      spi_div_cell #(
        .UW    (UW),
        .RW    (RW),
        .SHIFT (Q_BITS - 1 - gi)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (adv),
        .valid_in  (cv[gi]),
        .rem_s_in  (crs[gi]),
        .rem_t_in  (crt[gi]),
        .q_s_in    (cqs[gi]),
        .q_t_in    (cqt[gi]),
        .ud_in     (cud[gi]),
        .valid_out (cv[gi+1]),
        .rem_s_out (crs[gi+1]),
        .rem_t_out (crt[gi+1]),
        .q_s_out   (cqs[gi+1]),
        .q_t_out   (cqt[gi+1]),
        .ud_out    (cud[gi+1])
      );

      always_ff @(posedge clk) begin
        if (adv) begin
          cside[gi+1] <= cside[gi];
        end
      end
    end
  endgenerate

  // stage M1: sign and saturate the parameters
  function automatic logic signed [Q_BITS-1:0] sat_param(
    input logic [Q_BITS-1:0] q,
    input logic neg,
    input logic ovf
  );
    logic signed [Q_BITS-1:0] p_max, p_min, r;
    p_max = {1'b0, {(Q_BITS - 1){1'b1}}};
    p_min = {1'b1, {(Q_BITS - 1){1'b0}}};
    if (ovf) begin
      r = neg ? p_min : p_max;
    end else if (neg) begin
      r = (q > p_min) ? p_min : -q;
    end else begin
      r = q[Q_BITS-1] ? p_max : q;
    end
    return r;
  endfunction

  side_t sd;
  assign sd = cside[Q_BITS];

  logic m1_v;
  logic signed [Q_BITS-1:0] m1_ps, m1_pt;
  side_t m1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (adv) begin
      m1_v <= cv[Q_BITS];
    end
    if (adv) begin
      m1_ps   <= sat_param(cqs[Q_BITS], sd.neg_s, sd.ovf_s);
      m1_pt   <= sat_param(cqt[Q_BITS], sd.neg_t, sd.ovf_t);
      m1_side <= sd;
    end
  end

  // stage M2: parameter times segment direction
  logic m2_v;
  logic signed [Q_BITS-1:0] m2_ps, m2_pt;
  logic signed [MW-1:0] m2_mx, m2_my;
  side_t m2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (adv) begin
      m2_v <= m1_v;
    end
    if (adv) begin
      m2_mx   <= MW'(m1_ps) * MW'(m1_side.bax);
      m2_my   <= MW'(m1_ps) * MW'(m1_side.bay);
      m2_ps   <= m1_ps;
      m2_pt   <= m1_pt;
      m2_side <= m1_side;
    end
  end

  // output stage: add the start point, saturate, zero parameters and point unless REL_CROSS
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [PNT_BITS-1:0] px_w, py_w;
  logic is_cross;

  always_comb begin
    sum_x = (SW'(m2_side.ax) <<< FRAC_BITS) + SW'(m2_mx);
    sum_y = (SW'(m2_side.ay) <<< FRAC_BITS) + SW'(m2_my);
    if (sum_x > P48_MAX_W) begin
      px_w = PNT_BITS'(P48_MAX_W);
    end else if (sum_x < P48_MIN_W) begin
      px_w = PNT_BITS'(P48_MIN_W);
    end else begin
      px_w = PNT_BITS'(sum_x);
    end
    if (sum_y > P48_MAX_W) begin
      py_w = PNT_BITS'(P48_MAX_W);
    end else if (sum_y < P48_MIN_W) begin
      py_w = PNT_BITS'(P48_MIN_W);
    end else begin
      py_w = PNT_BITS'(sum_y);
    end
    is_cross = m2_side.rel == REL_CROSS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (adv) begin
      result_out.valid <= m2_v;
    end
    if (adv) begin
      result_out.relation         <= m2_side.rel;
      result_out.segments_cross   <= m2_side.crosses;
      result_out.segments_overlap <= m2_side.ovl;
      result_out.param_s          <= is_cross ? m2_ps : '0;
      result_out.param_t          <= is_cross ? m2_pt : '0;
      result_out.cross_x          <= is_cross ? px_w : '0;
      result_out.cross_y          <= is_cross ? py_w : '0;
      result_out.overlap_start_x  <= m2_side.sx;
      result_out.overlap_start_y  <= m2_side.sy;
      result_out.overlap_end_x    <= m2_side.ex;
      result_out.overlap_end_y    <= m2_side.ey;
    end
  end

endmodule
`default_nettype wire
